[sv/qnorm_pkg.sv]
package qnorm_pkg;

  localparam int FracBits  = 14;
  localparam int GuardBits = 8;
  localparam int PartW     = 16;
  localparam int SumW      = 34;
  localparam int SqW       = SumW + 2 * GuardBits;
  localparam int RootW     = SqW / 2;
  localparam int MagW      = 17;
  localparam int QuoW      = 16;
  localparam int NumW      = PartW + FracBits + GuardBits + 1;
  localparam int DivW      = RootW + 1;

  typedef logic signed [PartW-1:0] part_t;

  typedef struct packed {
    logic zero;
    logic unit;
    logic [3:0] neg;
  } flags_t;

endpackage

[sv/qnorm_div.sv]
module qnorm_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [qnorm_pkg::NumW-1:0] num,
  input  logic [qnorm_pkg::DivW-1:0] den,
  output logic [qnorm_pkg::QuoW-1:0] quo
);
  import qnorm_pkg::*;

  localparam int Steps = QuoW;
  localparam int RemW  = DivW + 1;

  logic [RemW-1:0] rem_r [Steps+1];
  logic [NumW-1:0] n_r   [Steps+1];
  logic [DivW-1:0] d_r   [Steps+1];
  logic [QuoW-1:0] q_r   [Steps+1];

  // preload the numerator bits above the quotient; they stay below den
  always_comb begin
    rem_r[0] = RemW'(num[NumW-1:QuoW]);
    n_r[0]   = num;
    d_r[0]   = den;
    q_r[0]   = '0;
  end

  // one restoring quotient bit per stage, MSB first; quotient fits QuoW bits
  for (genvar s = 0; s < Steps; s++) begin : g_st
    logic [RemW-1:0] sh;
    logic [RemW:0]   df;
    always_comb begin
      sh = {rem_r[s][RemW-2:0], n_r[s][QuoW-1-s]};
      df = {1'b0, sh} - {2'b0, d_r[s]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1] <= df[RemW] ? sh : df[RemW-1:0];
        q_r[s+1]   <= {q_r[s][QuoW-2:0], ~df[RemW]};
        n_r[s+1]   <= n_r[s];
        d_r[s+1]   <= d_r[s];
      end
    end
  end

  assign quo = q_r[Steps];

endmodule

[sv/quaternion_normalize.sv]
// channel | ports      | fields (low bit up)
// input   | in_tdata   | w_in[15:0] x_in[31:16] y_in[47:32] z_in[63:48]
// output  | out_tdata  | w_out x_out y_out z_out magnitude[80:64] zero_error[81], pad to 88
// One quaternion per cycle unless out_tready stalls the pipe. Data passes the square and sum
// registers, the bit-per-stage square root and restoring divide pipelines, and the output register.
// Reset clears valid bits only. A stall on out_tready freezes the whole pipe.
module quaternion_normalize (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // w_in, x_in, y_in, z_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata   // w_out, x_out, y_out, z_out, magnitude, zero_error
);
  import qnorm_pkg::*;

  localparam int RootSt = RootW;
  localparam int Lat    = 2 + RootSt + QuoW + 1;

  logic en;
  assign en = ~out_tvalid | out_tready;
  assign in_tready = en;

  logic [Lat-1:0] v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[Lat-2:0], in_tvalid};
  end
  assign out_tvalid = v_r[Lat-1];

  // square parts
  part_t p_r [4];
  logic [2*PartW-1:0] sq_r [4];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        p_r[i]  <= in_tdata[i*PartW +: PartW];
        sq_r[i] <= 32'($signed(in_tdata[i*PartW +: PartW]) *
                       $signed(in_tdata[i*PartW +: PartW]));
      end
    end
  end

  // sum squares
  logic [SumW-1:0] sum_r;
  part_t p2_r [4];
  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= SumW'(sq_r[0]) + SumW'(sq_r[1]) + SumW'(sq_r[2]) + SumW'(sq_r[3]);
      p2_r  <= p_r;
    end
  end

  // square root pipeline, one result bit per stage
  logic [SqW-1:0]   rv_r [RootSt+1];
  logic [RootW+1:0] rr_r [RootSt+1];
  logic [RootW-1:0] rq_r [RootSt+1];
  part_t            rp_r [RootSt+1][4];
  logic [SumW-1:0]  rs_r [RootSt+1];
  always_comb begin
    rv_r[0] = {sum_r, {(2*GuardBits){1'b0}}};
    rr_r[0] = '0;
    rq_r[0] = '0;
    rp_r[0] = p2_r;
    rs_r[0] = sum_r;
  end
  for (genvar s = 0; s < RootSt; s++) begin : g_rt
    logic [RootW+1:0] tr, tt;
    logic [RootW+2:0] df;
    always_comb begin
      tr = {rr_r[s][RootW-1:0], rv_r[s][SqW-1-2*s -: 2]};
      tt = {rq_r[s], 2'b01};
      df = {1'b0, tr} - {1'b0, tt};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rr_r[s+1] <= df[RootW+2] ? tr : df[RootW+1:0];
        rq_r[s+1] <= {rq_r[s][RootW-2:0], ~df[RootW+2]};
        rv_r[s+1] <= rv_r[s];
        rp_r[s+1] <= rp_r[s];
        rs_r[s+1] <= rs_r[s];
      end
    end
  end

  logic [RootW-1:0] d;
  assign d = rq_r[RootSt];

  // divide |p|*2^(F+G)*2 + d by 2d
  logic [QuoW-1:0] quo [4];
  for (genvar i = 0; i < 4; i++) begin : g_dv
    logic [PartW-1:0] a;
    logic [NumW-1:0]  nm;
    always_comb begin
      a  = rp_r[RootSt][i][PartW-1] ? PartW'(-rp_r[RootSt][i]) : rp_r[RootSt][i];
      nm = {a, {(FracBits+GuardBits+1){1'b0}}} + NumW'(d);
    end
    qnorm_div u_div (.clk(clk), .en(en), .num(nm), .den({d, 1'b0}), .quo(quo[i]));
  end

  // carry side data across the divider
  part_t           dp_r [QuoW+1][4];
  flags_t          df_r [QuoW+1];
  logic [MagW-1:0] dm_r [QuoW+1];
  always_comb begin
    dp_r[0] = rp_r[RootSt];
    dm_r[0] = MagW'(d >> GuardBits);
    df_r[0].zero = (rs_r[RootSt] == '0);
    df_r[0].unit = (rs_r[RootSt] == (SumW'(1) << (2*FracBits)));
    for (int i = 0; i < 4; i++) df_r[0].neg[i] = rp_r[RootSt][i][PartW-1];
  end
  for (genvar s = 0; s < QuoW; s++) begin : g_sd
    always_ff @(posedge clk) begin
      if (en) begin
        dp_r[s+1] <= dp_r[s];
        dm_r[s+1] <= dm_r[s];
        df_r[s+1] <= df_r[s];
      end
    end
  end

  // apply sign, special cases
  logic [87:0] od_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        if (df_r[QuoW].zero) od_r[i*16 +: 16] <= '0;
        else if (df_r[QuoW].unit) od_r[i*16 +: 16] <= dp_r[QuoW][i];
        else if (df_r[QuoW].neg[i]) od_r[i*16 +: 16] <= -quo[i];
        else od_r[i*16 +: 16] <= quo[i];
      end
      od_r[80:64] <= df_r[QuoW].zero ? '0 :
                     df_r[QuoW].unit ? MagW'(1 << FracBits) : dm_r[QuoW];
      od_r[81]    <= df_r[QuoW].zero;
      od_r[87:82] <= '0;
    end
  end
  assign out_tdata = od_r;

endmodule
